// ===== src/aarch64_branch_resolve_unit_top_defines.svh =====
// Assertion macros used by the checker of the branch resolve unit.
`ifndef AARCH64_BRANCH_RESOLVE_UNIT_TOP_DEFINES_SVH
`define AARCH64_BRANCH_RESOLVE_UNIT_TOP_DEFINES_SVH

// Overlapping implication, sampled on the rising clock edge, off during reset.
`define ABRU_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication into the next cycle, sampled on the rising clock edge, off during reset.
`define ABRU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/abru_pkg.sv =====
// Package with the request and result types and the decode constants of the branch resolve unit.
`timescale 1ns / 1ps

package abru_pkg;

   typedef enum logic [1:0] {
      OUT_NORMAL  = 2'd0,
      OUT_SYSCALL = 2'd1,
      OUT_BREAK   = 2'd2,
      OUT_UNDEF   = 2'd3
   } outcome_type;

   typedef struct packed {
      logic [31:0] instruction;
      logic [63:0] pc;
      logic [63:0] reg_value;
      logic [3:0]  flags;
   } req_type;

   typedef struct packed {
      logic [63:0] next_pc;
      logic        dest_write;
      logic [4:0]  dest_reg;
      logic [63:0] dest_value;
      outcome_type outcome;
   } rsp_type;

   localparam logic [31:0] SVC_MASK   = 32'hffe0001f;
   localparam logic [31:0] SVC_MATCH  = 32'hd4000001;
   localparam logic [31:0] BR_MASK    = 32'hfffffc1f;
   localparam logic [31:0] BR_MATCH   = 32'hd61f0000;
   localparam logic [31:0] BCOND_MASK = 32'hff000010;
   localparam logic [31:0] BCOND_MATCH = 32'h54000000;
   localparam logic [31:0] NOP_WORD   = 32'hd503201f;
   localparam logic [31:0] BRK_MASK   = 32'hffe00000;
   localparam logic [31:0] BRK_MATCH  = 32'hd4200000;
   localparam logic [4:0]  B_OP       = 5'h05;
   localparam logic [4:0]  ADR_OP     = 5'h10;
   localparam logic [4:0]  LINK_REG   = 5'd30;
   localparam logic [63:0] PAGE_MASK  = 64'hfff;
   localparam logic [63:0] INSN_BYTES = 64'd4;
   localparam int unsigned LATENCY    = 2;

endpackage

// ===== src/abru_resolve.sv =====
// Combinational decode and address resolution of one instruction request.
`timescale 1ns / 1ps

module abru_resolve (
   input  abru_pkg::req_type req,
   output abru_pkg::rsp_type rsp
);
   import abru_pkg::*;

   function automatic logic cond_holds(input logic [3:0] cond, input logic [3:0] nzcv);
      logic n;
      logic z;
      logic c;
      logic v;
      logic r;
      n = nzcv[3];
      z = nzcv[2];
      c = nzcv[1];
      v = nzcv[0];
      case (cond[3:1])
         3'd0:    r = z;
         3'd1:    r = c;
         3'd2:    r = n;
         3'd3:    r = v;
         3'd4:    r = c && !z;
         3'd5:    r = (n == v);
         3'd6:    r = !z && (n == v);
         default: r = 1'b1;
      endcase
      if (cond[0] && (cond != 4'hf)) begin
         r = !r;
      end
      return r;
   endfunction

   logic [31:0] w;
   logic [7:0]  top8;
   logic [63:0] seq_pc;
   logic [63:0] off_b;
   logic [63:0] off_19;
   logic [63:0] off_14;
   logic [63:0] adr_imm;
   logic [63:0] cb_test;
   logic [5:0]  tb_bit;

   assign w       = req.instruction;
   assign top8    = w[31:24];
   assign seq_pc  = req.pc + INSN_BYTES;
   assign off_b   = {{36{w[25]}}, w[25:0], 2'b00};
   assign off_19  = {{43{w[23]}}, w[23:5], 2'b00};
   assign off_14  = {{48{w[18]}}, w[18:5], 2'b00};
   assign adr_imm = {{43{w[23]}}, w[23:5], w[30:29]};
   assign cb_test = w[31] ? req.reg_value : {32'd0, req.reg_value[31:0]};
   assign tb_bit  = {w[31], w[23:19]};

   always_comb begin
      rsp.next_pc    = seq_pc;
      rsp.dest_write = 1'b0;
      rsp.dest_reg   = 5'd0;
      rsp.dest_value = 64'd0;
      rsp.outcome    = OUT_NORMAL;
      if ((w & SVC_MASK) == SVC_MATCH) begin
         rsp.outcome = OUT_SYSCALL;
      end else if ((w & BR_MASK) == BR_MATCH) begin
         rsp.next_pc = req.reg_value;
      end else if (w[30:26] == B_OP) begin
         rsp.next_pc = req.pc + off_b;
         if (w[31]) begin
            rsp.dest_write = 1'b1;
            rsp.dest_reg   = LINK_REG;
            rsp.dest_value = seq_pc;
         end
      end else if ((w & BCOND_MASK) == BCOND_MATCH) begin
         if (cond_holds(w[3:0], req.flags)) begin
            rsp.next_pc = req.pc + off_19;
         end
      end else if (top8 inside {8'h34, 8'h35, 8'hb4, 8'hb5}) begin
         if ((cb_test == 64'd0) != w[24]) begin
            rsp.next_pc = req.pc + off_19;
         end
      end else if (top8 inside {8'h36, 8'h37, 8'hb6, 8'hb7}) begin
         if (req.reg_value[tb_bit] == w[24]) begin
            rsp.next_pc = req.pc + off_14;
         end
      end else if (w[28:24] == ADR_OP) begin
         rsp.dest_write = 1'b1;
         rsp.dest_reg   = w[4:0];
         if (w[31]) begin
            rsp.dest_value = (req.pc & ~PAGE_MASK) + {adr_imm[51:0], 12'd0};
         end else begin
            rsp.dest_value = req.pc + adr_imm;
         end
      end else if (w == NOP_WORD) begin
         rsp.outcome = OUT_NORMAL;
      end else if ((w & BRK_MASK) == BRK_MATCH) begin
         rsp.outcome = OUT_BREAK;
      end else begin
         rsp.outcome = OUT_UNDEF;
      end
   end

endmodule

// ===== src/aarch64_branch_resolve_unit_top.sv =====
// Top level of the AArch64 branch resolve unit: request register, resolver and result register.
`timescale 1ns / 1ps
// A request carries one instruction word with its pc, one register operand and
// the NZCV flags. It is taken at a rising clock edge at which start is high and
// busy is low; busy is always low, so a new request may be given every cycle.
// The request is held in an input register, resolved by one pass of decode and
// 64-bit adders, and the result is captured in a result register.
// Each request yields exactly one result on rsp_data, marked by rsp_strobe for
// one cycle, once it has passed the input register and the result register.
// Throughput is one request per cycle.
// The result gives the next pc, an optional register write (BL, ADR, ADRP) and
// an outcome: normal, system call, breakpoint or undefined instruction.
// The receiver cannot stall: a result is taken in the cycle it is shown.
// A synchronous reset clears both valid flags, so no result appears until a
// request is taken after reset; requests in flight at reset are dropped.
module aarch64_branch_resolve_unit_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  abru_pkg::req_type req_data,
   output logic              rsp_strobe,
   output abru_pkg::rsp_type rsp_data
);
   import abru_pkg::*;

   req_type req_ff;
   req_type req_in;
   logic    req_valid_ff;
   logic    req_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;

   assign busy         = 1'b0;
   assign req_valid_in = start && !busy;
   assign req_in       = req_data;
   assign rsp_valid_in = req_valid_ff;

   abru_resolve u_resolve (
      .req (req_ff),
      .rsp (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_ff <= req_in;
      end
      if (rsp_valid_in) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== src/abru_checker.sv =====
// Port-level assertion checker for the branch resolve unit and its bind statement.
`timescale 1ns / 1ps
`include "aarch64_branch_resolve_unit_top_defines.svh"

module abru_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input abru_pkg::req_type req_data,
   input logic              rsp_strobe,
   input abru_pkg::rsp_type rsp_data
);
   import abru_pkg::*;

   logic accept;
   logic accept_d1;

   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         accept_d1 <= 1'b0;
      end else begin
         accept_d1 <= accept;
      end
   end

   // Every taken request produces a result on rsp_strobe.
   `ABRU_ASSERT_NEXT(a_result_follows, accept_d1, rsp_strobe, "request produced no result")

   // No result appears without a matching earlier request.
   `ABRU_ASSERT_SAME(a_no_stray_result, rsp_strobe, $past(accept, LATENCY), "result without request")

   // A result without a register write carries zero in the write fields.
   `ABRU_ASSERT_SAME(a_clean_write, rsp_strobe && !rsp_data.dest_write,
      (rsp_data.dest_reg == 5'd0) && (rsp_data.dest_value == 64'd0), "stale write fields")

   // Exceptions and undefined words never write and always continue at pc plus four.
   `ABRU_ASSERT_SAME(a_exception_seq, rsp_strobe && (rsp_data.outcome != OUT_NORMAL),
      !rsp_data.dest_write && (rsp_data.next_pc == $past(req_data.pc, LATENCY) + INSN_BYTES),
      "exception result not sequential")

endmodule

bind aarch64_branch_resolve_unit_top abru_checker u_abru_checker (.*);
